>>> rtl/cron_next_match_search_top_macros.svh
// assertion macros shared by the cron next-match search rtl
// no dependencies; included by the modules that carry checks
`ifndef CRON_NEXT_MATCH_SEARCH_TOP_MACROS_SVH
`define CRON_NEXT_MATCH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CNMS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CNMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cnms_pkg.sv
// types, constants and calendar functions for the cron next-match search
// no dependencies; used by every other rtl file but the assertion macro header
`default_nettype none

package cnms_pkg;

   localparam int YEAR_IN_W  = 12;
   localparam int YEAR_W     = 13;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int OFFSET_W   = 10;
   localparam int WD_W       = 3;
   localparam int DOY_W      = 9;
   localparam int ISO_W      = 6;
   localparam int WSUM_W     = 14;

   localparam int MIN_MASK_W  = 60;
   localparam int HOUR_MASK_W = 24;
   localparam int DOM_MASK_W  = 32;
   localparam int MON_MASK_W  = 13;
   localparam int WD_MASK_W   = 7;
   localparam int ISO_MASK_W  = 54;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_MINUTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOUR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MONTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WDAY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ISOWK  = 3'd5;

   // internal years carry this bias; the calendar repeats every 400 years
   localparam logic [YEAR_W-1:0] YEAR_BIAS = 13'd400;

   localparam logic [1:0] WD_SEL_JAN1_CUR  = 2'd0;
   localparam logic [1:0] WD_SEL_JAN1_PREV = 2'd1;
   localparam logic [1:0] WD_SEL_TODAY     = 2'd2;

   typedef struct packed {
      logic       load;
      logic [1:0] wd_sel;
      logic       store_cur53;
      logic       store_prev53;
      logic       store_today;
      logic       step;
      logic       skip_hit;
      logic       final_hit;
      logic       miss;
      logic       fail;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic input_ok;
      logic day_hit;
      logic at_limit;
      logic need_second;
   } sts_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [23:0] p;
      logic [6:0]  q;
      logic [13:0] c;
      logic        div100;
      p = y * 11'd1311;
      q = p[23:17];
      c = q * 7'd100;
      div100 = ({1'b0, y} == c);
      return (y[1:0] == 2'd0) && (!div100 || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m) inside
         4'd2: r = is_leap(y) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] sak_offset(input logic [MONTH_W-1:0] m);
      logic [3:0] r;
      case (m)
         4'd1: r = 4'd0;  4'd2: r = 4'd3;  4'd3: r = 4'd2;  4'd4: r = 4'd5;
         4'd5: r = 4'd0;  4'd6: r = 4'd3;  4'd7: r = 4'd5;  4'd8: r = 4'd1;
         4'd9: r = 4'd4;  4'd10: r = 4'd6; 4'd11: r = 4'd2; 4'd12: r = 4'd4;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // days of the year before the first of month m, february as 28
   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] r;
      case (m)
         4'd2: r = 9'd31;   4'd3: r = 9'd59;   4'd4: r = 9'd90;
         4'd5: r = 9'd120;  4'd6: r = 9'd151;  4'd7: r = 9'd181;
         4'd8: r = 9'd212;  4'd9: r = 9'd243;  4'd10: r = 9'd273;
         4'd11: r = 9'd304; 4'd12: r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // sakamoto sum before the mod 7
   function automatic logic [WSUM_W-1:0] weekday_sum(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [DAY_W-1:0] d);
      logic [YEAR_W-1:0] yy;
      logic [10:0]       q4;
      logic [23:0]       p1;
      logic [21:0]       p2;
      logic [6:0]        q100;
      logic [4:0]        q400;
      yy   = (m < 4'd3) ? (y - 13'd1) : y;
      q4   = yy[12:2];
      p1   = yy * 11'd1311;
      p2   = q4 * 11'd1311;
      q100 = p1[23:17];
      q400 = p2[21:17];
      return {1'b0, yy} + {3'b0, q4} - {7'b0, q100} + {9'b0, q400}
             + {10'b0, sak_offset(m)} + {9'b0, d};
   endfunction

   function automatic logic [WD_W-1:0] mod7(input logic [WSUM_W-1:0] s);
      logic [27:0] p;
      logic [11:0] q;
      logic [14:0] t;
      logic [WSUM_W-1:0] r;
      p = s * 14'd9363;
      q = p[27:16];
      t = q * 3'd7;
      r = s - t[WSUM_W-1:0];
      return r[WD_W-1:0];
   endfunction

   function automatic logic [MIN_W-1:0] first_set60(input logic [MIN_MASK_W-1:0] v);
      logic [MIN_W-1:0] r;
      r = '0;
      for (int i = MIN_MASK_W - 1; i >= 0; i--) begin
         if (v[i]) r = MIN_W'(i);
      end
      return r;
   endfunction

   function automatic logic [HOUR_W-1:0] first_set24(input logic [HOUR_MASK_W-1:0] v);
      logic [HOUR_W-1:0] r;
      r = '0;
      for (int i = HOUR_MASK_W - 1; i >= 0; i--) begin
         if (v[i]) r = HOUR_W'(i);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cnms_if.sv
// valid/ready channel interfaces for query and result transfers
// depends on cnms_pkg for field widths
`default_nettype none

interface cnms_req_if import cnms_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [YEAR_IN_W-1:0] cur_year;
   logic [MONTH_W-1:0]   cur_month;
   logic [DAY_W-1:0]     cur_day;
   logic [HOUR_W-1:0]    cur_hour;
   logic [MIN_W-1:0]     cur_minute;
   logic                 skip_first;

   modport source (output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                   skip_first, input ready);
   modport sink (input valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                 skip_first, output ready);
endinterface

interface cnms_rsp_if import cnms_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] offset_days;
   logic [HOUR_W-1:0]   match_hour;
   logic [MIN_W-1:0]    match_minute;

   modport source (output valid, found, offset_days, match_hour, match_minute,
                   input ready);
   modport sink (input valid, found, offset_days, match_hour, match_minute,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/cnms_dpath.sv
// datapath: mask registers, date walker, weekday unit, iso week and match logic
// depends on cnms_pkg; driven by cnms_ctrl through cmd_type and sts_type
`default_nettype none

module cnms_dpath import cnms_pkg::*; #(
   parameter int DAY_SCAN_LIMIT = 400
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [YEAR_IN_W-1:0]  cur_year,
   input  wire logic [MONTH_W-1:0]    cur_month,
   input  wire logic [DAY_W-1:0]      cur_day,
   input  wire logic [HOUR_W-1:0]     cur_hour,
   input  wire logic [MIN_W-1:0]      cur_minute,
   input  wire logic                  skip_first,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   output logic                       found,
   output logic [OFFSET_W-1:0]        offset_days,
   output logic [HOUR_W-1:0]          match_hour,
   output logic [MIN_W-1:0]           match_minute
);

   localparam int OFF_W = $clog2(DAY_SCAN_LIMIT + 1);
   localparam int SUM_W = (OFF_W + 1 > OFFSET_W) ? OFF_W + 1 : OFFSET_W;

   logic [MIN_MASK_W-1:0]  min_mask_ff;
   logic [HOUR_MASK_W-1:0] hour_mask_ff;
   logic [DOM_MASK_W-1:0]  dom_mask_ff;
   logic [MON_MASK_W-1:0]  mon_mask_ff;
   logic [WD_MASK_W-1:0]   wd_mask_ff;
   logic [ISO_MASK_W-1:0]  iso_mask_ff;

   logic [YEAR_W-1:0]  y_ff, y_in;
   logic [MONTH_W-1:0] m_ff, m_in;
   logic [DAY_W-1:0]   d_ff, d_in;
   logic [HOUR_W-1:0]  fh_ff, fh_in;
   logic [MIN_W-1:0]   fmin_ff, fmin_in;
   logic               skip_ff, skip_in;
   logic [WD_W-1:0]    wd_ff, wd_in;
   logic [DOY_W-1:0]   doy_ff, doy_in;
   logic               cur53_ff, cur53_in;
   logic               prev53_ff, prev53_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic               found1_ff, found1_in;
   logic [OFF_W-1:0]   off1_ff, off1_in;
   logic [HOUR_W-1:0]  h1_ff, h1_in;
   logic [MIN_W-1:0]   m1_ff, m1_in;

   logic                res_found_ff, res_found_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [HOUR_W-1:0]   res_h_ff, res_h_in;
   logic [MIN_W-1:0]    res_m_ff, res_m_in;

   logic                out_found_ff;
   logic [OFFSET_W-1:0] out_off_ff;
   logic [HOUR_W-1:0]   out_h_ff;
   logic [MIN_W-1:0]    out_m_ff;

   // weekday unit operands
   logic [YEAR_W-1:0]  wy;
   logic [MONTH_W-1:0] wm;
   logic [DAY_W-1:0]   wday;
   logic [WD_W-1:0]    wd_res;
   logic               leap_cur;
   logic               leap_prev;
   logic               leap_next;

   // per-day evaluation
   logic [3:0]             iso_wd;
   logic [DOY_W-1:0]       wk_num;
   logic [17:0]            wk_prod;
   logic [6:0]             wk_raw;
   logic [ISO_W-1:0]       iso_wk;
   logic                   date_ok;
   logic [MIN_MASK_W-1:0]  min_after;
   logic [HOUR_MASK_W-1:0] hour_after;
   logic [HOUR_MASK_W-1:0] hour_same;
   logic                   day0;
   logic                   same_hour_ok;
   logic                   time_ok;
   logic [HOUR_W-1:0]      hit_h;
   logic [MIN_W-1:0]       hit_m;
   logic [DAY_W-1:0]       mlen;
   logic [WD_W-1:0]        wd_next;
   logic [SUM_W-1:0]       tot_off;
   logic [OFF_W-1:0]       off1_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mask_ff  <= '0;
         hour_mask_ff <= '0;
         dom_mask_ff  <= '0;
         mon_mask_ff  <= '0;
         wd_mask_ff   <= '0;
         iso_mask_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MINUTE: min_mask_ff  <= csr_wdata[MIN_MASK_W-1:0];
            CSR_HOUR:   hour_mask_ff <= csr_wdata[HOUR_MASK_W-1:0];
            CSR_DOM:    dom_mask_ff  <= csr_wdata[DOM_MASK_W-1:0];
            CSR_MONTH:  mon_mask_ff  <= csr_wdata[MON_MASK_W-1:0];
            CSR_WDAY:   wd_mask_ff   <= csr_wdata[WD_MASK_W-1:0];
            CSR_ISOWK:  iso_mask_ff  <= csr_wdata[ISO_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // weekday unit: sum registered, mod 7 on the next cycle
   always_comb begin
      unique case (cmd.wd_sel)
         WD_SEL_JAN1_CUR: begin
            wy = y_ff; wm = 4'd1; wday = 5'd1;
         end
         WD_SEL_JAN1_PREV: begin
            wy = y_ff - 13'd1; wm = 4'd1; wday = 5'd1;
         end
         WD_SEL_TODAY: begin
            wy = y_ff; wm = m_ff; wday = d_ff;
         end
         default: begin
            wy = y_ff; wm = m_ff; wday = d_ff;
         end
      endcase
      wsum_in   = weekday_sum(wy, wm, wday);
      wd_res    = mod7(wsum_ff);
      leap_cur  = is_leap(y_ff);
      leap_prev = is_leap(y_ff - 13'd1);
      leap_next = is_leap(y_ff + 13'd1);
   end

   // iso week of the current date
   always_comb begin
      iso_wd  = (wd_ff == 3'd0) ? 4'd7 : {1'b0, wd_ff};
      wk_num  = doy_ff + 9'd10 - {5'b0, iso_wd};
      wk_prod = wk_num * 9'd293;
      wk_raw  = wk_prod[17:11];
      if (wk_raw == 7'd0)
         iso_wk = prev53_ff ? 6'd53 : 6'd52;
      else if (wk_raw > 7'd52 && !cur53_ff)
         iso_wk = 6'd1;
      else
         iso_wk = wk_raw[ISO_W-1:0];
      date_ok = (m_ff <= 4'd12) && mon_mask_ff[m_ff] && dom_mask_ff[d_ff]
                && wd_mask_ff[wd_ff] && iso_mask_ff[iso_wk];
   end

   // first allowed time of the day
   always_comb begin
      for (int i = 0; i < MIN_MASK_W; i++)
         min_after[i] = min_mask_ff[i] && (MIN_W'(i) > fmin_ff);
      for (int i = 0; i < HOUR_MASK_W; i++) begin
         hour_after[i] = hour_mask_ff[i] && (HOUR_W'(i) > fh_ff);
         hour_same[i]  = hour_mask_ff[i] && (HOUR_W'(i) == fh_ff);
      end
      day0         = (off_ff == '0);
      same_hour_ok = (|hour_same) && (|min_after);
      if (!day0) begin
         time_ok = 1'b1;
         hit_h   = first_set24(hour_mask_ff);
         hit_m   = first_set60(min_mask_ff);
      end else if (same_hour_ok) begin
         time_ok = 1'b1;
         hit_h   = fh_ff;
         hit_m   = first_set60(min_after);
      end else begin
         time_ok = |hour_after;
         hit_h   = first_set24(hour_after);
         hit_m   = first_set60(min_mask_ff);
      end
   end

   always_comb begin
      mlen    = month_len(y_ff, m_ff);
      wd_next = (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
      off1_sel = found1_ff ? off1_ff : '0;
      tot_off = SUM_W'(off1_sel) + SUM_W'(off_ff);

      sts.input_ok = (|min_mask_ff) && (|hour_mask_ff) && (|dom_mask_ff)
                     && (|mon_mask_ff) && (|wd_mask_ff) && (|iso_mask_ff)
                     && (m_ff >= 4'd1) && (m_ff <= 4'd12) && (d_ff >= 5'd1)
                     && (d_ff <= mlen);
      sts.day_hit     = date_ok && time_ok;
      sts.at_limit    = (off_ff == OFF_W'(DAY_SCAN_LIMIT));
      sts.need_second = skip_ff && !found1_ff;
   end

   always_comb begin
      y_in = y_ff; m_in = m_ff; d_in = d_ff;
      fh_in = fh_ff; fmin_in = fmin_ff; skip_in = skip_ff;
      wd_in = wd_ff; doy_in = doy_ff;
      cur53_in = cur53_ff; prev53_in = prev53_ff;
      off_in = off_ff; found1_in = found1_ff;
      off1_in = off1_ff; h1_in = h1_ff; m1_in = m1_ff;
      res_found_in = res_found_ff; res_off_in = res_off_ff;
      res_h_in = res_h_ff; res_m_in = res_m_ff;

      if (cmd.load) begin
         y_in      = {1'b0, cur_year} + YEAR_BIAS;
         m_in      = cur_month;
         d_in      = cur_day;
         fh_in     = cur_hour;
         fmin_in   = cur_minute;
         skip_in   = skip_first;
         off_in    = '0;
         found1_in = 1'b0;
      end
      if (cmd.store_cur53)
         cur53_in = (wd_res == 3'd4) || (leap_cur && wd_res == 3'd3);
      if (cmd.store_prev53)
         prev53_in = (wd_res == 3'd4) || (leap_prev && wd_res == 3'd3);
      if (cmd.store_today) begin
         wd_in  = wd_res;
         doy_in = cum_days(m_ff) + {4'b0, d_ff}
                  + {8'b0, (leap_cur && m_ff > 4'd2)};
      end
      if (cmd.step) begin
         off_in = off_ff + OFF_W'(1);
         wd_in  = wd_next;
         if (d_ff < mlen) begin
            d_in   = d_ff + 5'd1;
            doy_in = doy_ff + 9'd1;
         end else if (m_ff < 4'd12) begin
            d_in   = 5'd1;
            m_in   = m_ff + 4'd1;
            doy_in = doy_ff + 9'd1;
         end else begin
            // new year: the old year's long-year flag moves back one
            d_in      = 5'd1;
            m_in      = 4'd1;
            y_in      = y_ff + 13'd1;
            doy_in    = 9'd1;
            prev53_in = cur53_ff;
            cur53_in  = (wd_next == 3'd4) || (leap_next && wd_next == 3'd3);
         end
      end
      if (cmd.skip_hit) begin
         found1_in = 1'b1;
         off1_in   = off_ff;
         h1_in     = hit_h;
         m1_in     = hit_m;
         fh_in     = hit_h;
         fmin_in   = hit_m;
         off_in    = '0;
      end
      if (cmd.final_hit) begin
         res_found_in = 1'b1;
         res_off_in   = tot_off[OFFSET_W-1:0];
         res_h_in     = hit_h;
         res_m_in     = hit_m;
      end
      if (cmd.miss) begin
         res_found_in = found1_ff;
         res_off_in   = found1_ff ? OFFSET_W'(off1_ff) : '0;
         res_h_in     = found1_ff ? h1_ff : '0;
         res_m_in     = found1_ff ? m1_ff : '0;
      end
      if (cmd.fail) begin
         res_found_in = 1'b0;
         res_off_in   = '0;
         res_h_in     = '0;
         res_m_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found1_ff <= 1'b0;
         off_ff    <= '0;
      end else begin
         found1_ff <= found1_in;
         off_ff    <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in; m_ff <= m_in; d_ff <= d_in;
      fh_ff <= fh_in; fmin_ff <= fmin_in; skip_ff <= skip_in;
      wd_ff <= wd_in; doy_ff <= doy_in;
      cur53_ff <= cur53_in; prev53_ff <= prev53_in;
      wsum_ff <= wsum_in;
      off1_ff <= off1_in; h1_ff <= h1_in; m1_ff <= m1_in;
      res_found_ff <= res_found_in; res_off_ff <= res_off_in;
      res_h_ff <= res_h_in; res_m_ff <= res_m_in;
      if (cmd.out_load) begin
         out_found_ff <= res_found_ff;
         out_off_ff   <= res_off_ff;
         out_h_ff     <= res_h_ff;
         out_m_ff     <= res_m_ff;
      end
   end

   assign found        = out_found_ff;
   assign offset_days  = out_off_ff;
   assign match_hour   = out_h_ff;
   assign match_minute = out_m_ff;

endmodule

`default_nettype wire

>>> rtl/cnms_ctrl.sv
// controller: sequences start-up, the day walk, the skip pass and result transfer
// depends on cnms_pkg and the assertion macro header
`default_nettype none
`include "cron_next_match_search_top_macros.svh"

module cnms_ctrl import cnms_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_WD1    = 3'd2;
   localparam logic [2:0] ST_WD2    = 3'd3;
   localparam logic [2:0] ST_WD3    = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!sts.input_ok) begin
               cmd.fail = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.wd_sel = WD_SEL_JAN1_CUR;
               state_in   = ST_WD1;
            end
         end
         ST_WD1: begin
            cmd.wd_sel      = WD_SEL_JAN1_PREV;
            cmd.store_cur53 = 1'b1;
            state_in        = ST_WD2;
         end
         ST_WD2: begin
            cmd.wd_sel       = WD_SEL_TODAY;
            cmd.store_prev53 = 1'b1;
            state_in         = ST_WD3;
         end
         ST_WD3: begin
            cmd.store_today = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.day_hit) begin
               if (sts.need_second) begin
                  cmd.skip_hit = 1'b1;
               end else begin
                  cmd.final_hit = 1'b1;
                  state_in      = ST_FINISH;
               end
            end else if (sts.at_limit) begin
               cmd.miss = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `CNMS_ASSERT_NEXT(a_accept_checks, clock, reset, req_valid && req_ready, state_ff == ST_CHECK, "accepted query did not start checking")
   `CNMS_ASSERT_IMP(a_load_when_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "result loaded over a pending transfer")
   `CNMS_ASSERT_NEXT(a_final_finishes, clock, reset, state_ff == ST_SCAN && sts.day_hit && !sts.need_second, state_ff == ST_FINISH, "final match did not finish the search")
   `CNMS_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.out_load, rsp_valid_ff && state_ff == ST_IDLE, "result not presented after load")

endmodule

`default_nettype wire

>>> rtl/cron_next_match_search_top.sv
// top level of the cron next-match search: controller, datapath and channel ports
// depends on cnms_pkg, cnms_if, cnms_ctrl and cnms_dpath
`default_nettype none

// Finds the first minute strictly after the query's date and time that all six cron
// masks allow, optionally skipping one match. One query is in work at a time. After
// its transfer a query passes an input check (a failed check ends it with not found)
// and three overlapped passes through the weekday unit, whose sum is registered, then
// takes one cycle per calendar day examined, at most DAY_SCAN_LIMIT+1 days, or
// 2*DAY_SCAN_LIMIT+2 with skip_first set, before the result register is loaded.
// A finished result waits in its own output register while the next query is
// taken in. Mask registers reset to zero and may be written only while no query
// is in work.
module cron_next_match_search_top import cnms_pkg::*; #(
   parameter int DAY_SCAN_LIMIT = 400
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   cnms_req_if.sink                   req_chan,
   cnms_rsp_if.source                 rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   cnms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cnms_dpath #(
      .DAY_SCAN_LIMIT (DAY_SCAN_LIMIT)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cur_year     (req_chan.cur_year),
      .cur_month    (req_chan.cur_month),
      .cur_day      (req_chan.cur_day),
      .cur_hour     (req_chan.cur_hour),
      .cur_minute   (req_chan.cur_minute),
      .skip_first   (req_chan.skip_first),
      .cmd          (cmd),
      .sts          (sts),
      .found        (rsp_chan.found),
      .offset_days  (rsp_chan.offset_days),
      .match_hour   (rsp_chan.match_hour),
      .match_minute (rsp_chan.match_minute)
   );

endmodule

`default_nettype wire

>>> tb/cron_next_match_search_top_tb.sv
// self-checking bench for the cron next-match search: directed and random queries
// against a behavioural search model; depends on cnms_pkg, cnms_if and the rtl top
`default_nettype none

module cron_next_match_search_top_tb;
   import cnms_pkg::*;

   localparam int SCAN_DAYS   = 400;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      bit [YEAR_IN_W-1:0] year;
      bit [MONTH_W-1:0]   month;
      bit [DAY_W-1:0]     day;
      bit [HOUR_W-1:0]    hour;
      bit [MIN_W-1:0]     minute;
      bit                 skip;
   } query_type;

   typedef struct {
      bit                found;
      bit [OFFSET_W-1:0] days;
      bit [HOUR_W-1:0]   hour;
      bit [MIN_W-1:0]    minute;
   } match_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cnms_req_if req_chan ();
   cnms_rsp_if rsp_chan ();

   cron_next_match_search_top #(.DAY_SCAN_LIMIT(SCAN_DAYS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // shadow copies of the mask registers
   bit [MIN_MASK_W-1:0]  minute_allow;
   bit [HOUR_MASK_W-1:0] hour_allow;
   bit [DOM_MASK_W-1:0]  dom_allow;
   bit [MON_MASK_W-1:0]  month_allow;
   bit [WD_MASK_W-1:0]   wday_allow;
   bit [ISO_MASK_W-1:0]  isowk_allow;

   match_type pending_matches[$];
   bit     failed;
   bit     no_idle;
   int     rsp_hold;
   int     quiet_cycles;

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- calendar model
   function automatic bit leap_year(int y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(int y, int m);
      case (m)
         2: return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic int day_of_week(int y, int m, int d);
      int t[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      if (m < 3) y = y - 1;
      return (y + y / 4 - y / 100 + y / 400 + t[m-1] + d) % 7;
   endfunction

   function automatic bit long_iso_year(int y);
      int w;
      w = day_of_week(y, 1, 1);
      return w == 4 || (leap_year(y) && w == 3);
   endfunction

   function automatic int iso_week_of(int y, int m, int d);
      int doy;
      int wd;
      int wk;
      doy = d;
      for (int k = 1; k < m; k++) doy += days_in_month(y, k);
      wd = day_of_week(y, m, d);
      if (wd == 0) wd = 7;
      wk = (doy + 10 - wd) / 7;
      if (wk < 1) return long_iso_year(y - 1) ? 53 : 52;
      if (wk > 52 && !long_iso_year(y)) return 1;
      return wk;
   endfunction

   // walks days from the given date; returns the day offset of the first match or -1
   function automatic int walk_days(inout int y, inout int m, inout int d,
                                    input int start_h, input int start_min,
                                    output int hit_h, output int hit_min);
      int h0;
      int m0;
      hit_h = 0;
      hit_min = 0;
      for (int off = 0; off <= SCAN_DAYS; off++) begin
         if (off > 0) begin
            if (d < days_in_month(y, m)) d++;
            else begin
               d = 1;
               if (m < 12) m++;
               else begin
                  m = 1;
                  y++;
               end
            end
         end
         if (!month_allow[m] || !dom_allow[d] || !wday_allow[day_of_week(y, m, d)]
             || !isowk_allow[iso_week_of(y, m, d)]) continue;
         h0 = (off == 0) ? start_h : 0;
         for (int h = h0; h <= 23; h++) begin
            if (!hour_allow[h]) continue;
            m0 = (off == 0 && h == start_h) ? start_min + 1 : 0;
            for (int mi = m0; mi <= 59; mi++) begin
               if (minute_allow[mi]) begin
                  hit_h = h;
                  hit_min = mi;
                  return off;
               end
            end
         end
      end
      return -1;
   endfunction

   function automatic match_type next_match(query_type q);
      match_type r;
      int y, m, d, h1, m1, h2, m2, off1, off2;
      r = '{default: 0};
      y = int'(q.year) + 400;
      m = int'(q.month);
      d = int'(q.day);
      if (minute_allow == 0 || hour_allow == 0 || dom_allow == 0 || month_allow == 0
          || wday_allow == 0 || isowk_allow == 0) return r;
      if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) return r;
      off1 = walk_days(y, m, d, int'(q.hour), int'(q.minute), h1, m1);
      if (off1 < 0) return r;
      if (q.skip) begin
         off2 = walk_days(y, m, d, h1, m1, h2, m2);
         if (off2 >= 0) begin
            off1 += off2;
            h1 = h2;
            m1 = m2;
         end
      end
      r.found = 1'b1;
      r.days = off1[OFFSET_W-1:0];
      r.hour = h1[HOUR_W-1:0];
      r.minute = m1[MIN_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic write_mask(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_MINUTE: minute_allow = value[MIN_MASK_W-1:0];
         CSR_HOUR:   hour_allow   = value[HOUR_MASK_W-1:0];
         CSR_DOM:    dom_allow    = value[DOM_MASK_W-1:0];
         CSR_MONTH:  month_allow  = value[MON_MASK_W-1:0];
         CSR_WDAY:   wday_allow   = value[WD_MASK_W-1:0];
         CSR_ISOWK:  isowk_allow  = value[ISO_MASK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(logic [CSR_DATA_W-1:0] mi, logic [CSR_DATA_W-1:0] hr,
                            logic [CSR_DATA_W-1:0] dm, logic [CSR_DATA_W-1:0] mo,
                            logic [CSR_DATA_W-1:0] wd, logic [CSR_DATA_W-1:0] iw);
      write_mask(CSR_MINUTE, mi);
      write_mask(CSR_HOUR, hr);
      write_mask(CSR_DOM, dm);
      write_mask(CSR_MONTH, mo);
      write_mask(CSR_WDAY, wd);
      write_mask(CSR_ISOWK, iw);
   endtask

   task automatic send_query(query_type q);
      int gap;
      @(negedge clock);
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.cur_year = q.year;
      req_chan.cur_month = q.month;
      req_chan.cur_day = q.day;
      req_chan.cur_hour = q.hour;
      req_chan.cur_minute = q.minute;
      req_chan.skip_first = q.skip;
      do @(posedge clock); while (!req_chan.ready);
      pending_matches.push_back(next_match(q));
   endtask

   task automatic send_date(int y, int mo, int d, int h, int mi, bit sk);
      query_type q;
      q.year = YEAR_IN_W'(y);
      q.month = MONTH_W'(mo);
      q.day = DAY_W'(d);
      q.hour = HOUR_W'(h);
      q.minute = MIN_W'(mi);
      q.skip = sk;
      send_query(q);
   endtask

   // drains the block before masks change or the sender resumes
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic query_type random_query();
      query_type q;
      q.year = YEAR_IN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(1970, 4000));
      q.month = MONTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 12));
      q.day = DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 28));
      q.hour = HOUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 23));
      q.minute = MIN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 59));
      q.skip = 1'($urandom_range(0, 1));
      return q;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_mask(int lo, int hi);
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      case ($urandom_range(0, 3))
         0: v = '1;
         1: v[$urandom_range(lo, hi)] = 1'b1;
         2: v = CSR_DATA_W'({$urandom, $urandom});
         default: for (int i = 0; i < 4; i++) v[$urandom_range(lo, hi)] = 1'b1;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------- response side
   initial begin
      int gap;
      match_type exp_m;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (pending_matches.size() == 0) begin
            $display("%0t: result transfer with none expected", $time);
            failed = 1'b1;
         end else begin
            exp_m = pending_matches.pop_front();
            if (rsp_chan.found !== exp_m.found) begin
               $display("%0t: found expected %0d actual %0d", $time, exp_m.found,
                        rsp_chan.found);
               failed = 1'b1;
            end
            if (rsp_chan.offset_days !== exp_m.days) begin
               $display("%0t: offset_days expected %0d actual %0d", $time, exp_m.days,
                        rsp_chan.offset_days);
               failed = 1'b1;
            end
            if (rsp_chan.match_hour !== exp_m.hour) begin
               $display("%0t: match_hour expected %0d actual %0d", $time, exp_m.hour,
                        rsp_chan.match_hour);
               failed = 1'b1;
            end
            if (rsp_chan.match_minute !== exp_m.minute) begin
               $display("%0t: match_minute expected %0d actual %0d", $time, exp_m.minute,
                        rsp_chan.match_minute);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_zero_masks();
      send_date(2024, 6, 15, 12, 30, 0);
      send_date(2024, 6, 15, 12, 30, 1);
      wait_idle();
      // one register still zero is enough for not found
      write_all('1, '1, '1, '1, '1, '0);
      send_date(2000, 1, 1, 0, 0, 0);
      wait_idle();
   endtask

   task automatic test_calendar_edges();
      write_all('1, '1, '1, '1, '1, '1);
      send_date(0, 1, 1, 0, 0, 0);
      send_date(4095, 12, 31, 23, 59, 0);
      send_date(4095, 12, 31, 23, 59, 1);
      send_date(2023, 2, 29, 10, 0, 0);     // not a leap year
      send_date(2024, 2, 29, 10, 0, 0);
      send_date(1900, 2, 29, 10, 0, 0);     // century, not leap
      send_date(2000, 2, 29, 23, 59, 1);    // 400-year leap
      send_date(2024, 0, 10, 5, 5, 0);      // bad month
      send_date(2024, 15, 10, 5, 5, 0);
      send_date(2024, 4, 31, 5, 5, 0);      // bad day
      send_date(2024, 4, 0, 5, 5, 0);
      send_date(2024, 4, 30, 31, 63, 0);    // hour and minute beyond range
      send_date(2024, 4, 30, 23, 59, 1);
      send_date(2024, 4, 30, 12, 58, 0);
      wait_idle();
      // only week 53, minute 0 of hour 0: long scans and year-edge weeks
      write_all(60'h1, 60'h1, '1, '1, '1, 60'h1 << 53);
      send_date(2020, 1, 1, 0, 0, 0);
      send_date(2021, 6, 1, 0, 0, 1);
      send_date(2015, 12, 27, 0, 0, 1);
      wait_idle();
      write_all(60'h1 << 59, 60'h1 << 23, '1, '1, 60'h1, (60'h1 << 52) | 60'h2);
      send_date(2026, 12, 20, 0, 0, 0);
      send_date(2027, 12, 26, 23, 59, 1);
      wait_idle();
   endtask

   task automatic test_unreachable();
      // only bit zero of the month mask: nonzero yet never selected
      write_all('1, '1, '1, 60'h1, '1, '1);
      send_date(2024, 3, 3, 3, 3, 0);
      wait_idle();
      // february 30th, thursday only
      write_all(60'h3, 60'h1, 60'h1 << 30, 60'h4, 60'h10, '1);
      send_date(2024, 1, 1, 0, 0, 1);
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_all('1, 60'h1 << 7, '1, '1, '1, '1);
      rsp_hold = 600;
      repeat (8) send_query(random_query());
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 12; ph++) begin
         write_all(random_mask(0, 59), random_mask(0, 23), random_mask(1, 31),
                   random_mask(1, 12), random_mask(0, 6), random_mask(1, 53));
         no_idle = (ph % 4 == 3);
         repeat (22) send_query(random_query());
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.cur_year = '0;
      req_chan.cur_month = '0;
      req_chan.cur_day = '0;
      req_chan.cur_hour = '0;
      req_chan.cur_minute = '0;
      req_chan.skip_first = 1'b0;
      failed = 1'b0;
      no_idle = 1'b0;
      rsp_hold = 0;
      quiet_cycles = 0;
      minute_allow = '0;
      hour_allow = '0;
      dom_allow = '0;
      month_allow = '0;
      wday_allow = '0;
      isowk_allow = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_zero_masks();
      test_calendar_edges();
      test_unreachable();
      test_backpressure();
      test_random_phases();

      wait_idle();
      repeat (900) @(posedge clock);
      if (!failed && pending_matches.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/cnms_pkg.sv
rtl/cnms_if.sv
rtl/cnms_dpath.sv
rtl/cnms_ctrl.sv
rtl/cron_next_match_search_top.sv
tb/cron_next_match_search_top_tb.sv
